// ----- hdl/bcts_pkg.sv -----
// ============================================================================
// bcts_pkg
// Shared widths, codes and types of the bilinear cover / tile scaler.
// ============================================================================
`default_nettype none

package bcts_pkg;

  // Source pixel store
  localparam int unsigned MaxSourcePixels = 65536;
  localparam int unsigned AddrW           = $clog2(MaxSourcePixels);
  localparam int unsigned PixW            = 32;

  // Image and screen geometry
  localparam int unsigned MaxSrcDim    = 256;
  localparam int unsigned SrcDimW      = 9;
  localparam int unsigned MaxScreenDim = 4096;
  localparam int unsigned ScrDimW      = 13;
  localparam int unsigned DestW        = 12;

  // 9.16 fixed point step
  localparam int unsigned FracW = 16;
  localparam int unsigned KW    = SrcDimW + FracW;

  // Ports
  localparam int unsigned RgbW     = 24;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_SCR_W  = 3'd2,
    REG_SCR_H  = 3'd3,
    REG_TILE   = 3'd4
  } reg_e;

  typedef logic [RgbW-1:0] rgb_t;

endpackage

`default_nettype wire

// ----- hdl/bilinear_cover_or_tile_scaler.sv -----
// ============================================================================
// bilinear_cover_or_tile_scaler
// Source ARGB pixel store with bilinear cover scaling or tiled lookup.
// ============================================================================
// A write beat stores one source pixel with one access of the single memory
// port; a request beat reads four neighbours from it in turn and holds it
// until the last read issues. Writes are taken every cycle unless setup, reads
// or a stalled output hold the pipeline. A request passes five address stages,
// the memory stage, a gather register, a horizontal blend register and the
// output register, which takes the vertical blend. After reset and every
// configuration write a serial divider shared by both axes works out the scale step,
// then the centring offsets, while s_axis_tready stays low. The store needs no
// clearing pass if entries are read only once written; the user must keep to this, the block does not enforce it.
`default_nettype none

module bilinear_cover_or_tile_scaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bcts_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pixel_index[15:0], pixel_value[47:16], dest_x[59:48], dest_y[71:60]
  input  logic [bcts_pkg::InDataW-1:0]  s_axis_tdata,
  // operation[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // screen_rgb[23:0]
  output logic [bcts_pkg::RgbW-1:0]     m_axis_tdata
);
  import bcts_pkg::*;

  localparam int unsigned RemW    = SrcDimW - 1;
  localparam int unsigned DivCntW = $clog2(KW);
  localparam int unsigned OffW    = KW - 1;
  localparam int unsigned ProdW   = KW + DestW;
  localparam int unsigned PW      = ProdW + 1;
  localparam int unsigned HalfPix = 1 << (FracW - 1);

  typedef enum logic [7:0] {
    SU_LOAD_X = 8'b0000_0001,
    SU_DIV_X  = 8'b0000_0010,
    SU_LOAD_Y = 8'b0000_0100,
    SU_DIV_Y  = 8'b0000_1000,
    SU_MIN    = 8'b0001_0000,
    SU_MUL    = 8'b0010_0000,
    SU_OFF    = 8'b0100_0000,
    SU_RDY    = 8'b1000_0000
  } setup_e;

  typedef struct packed {
    logic [RemW-1:0] i0;
    logic [RemW-1:0] i1;
    logic [7:0]      w;
  } axis_t;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [SrcDimW-1:0] clamp_src(logic [SrcDimW-1:0] v);
    if (v == '0) return SrcDimW'(1);
    if (v > SrcDimW'(MaxSrcDim)) return SrcDimW'(MaxSrcDim);
    return v;
  endfunction

  function automatic logic [ScrDimW-1:0] clamp_scr(logic [ScrDimW-1:0] v);
    if (v == '0) return ScrDimW'(1);
    if (v > ScrDimW'(MaxScreenDim)) return ScrDimW'(MaxScreenDim);
    return v;
  endfunction

  // Three restoring remainder steps, most significant bit first
  function automatic logic [RemW-1:0] mod_step3(logic [RemW-1:0] rem, logic [2:0] bits,
                                                logic [SrcDimW-1:0] d);
    logic [SrcDimW-1:0] sh;
    logic [RemW-1:0]    r;
    r = rem;
    for (int i = 2; i >= 0; i--) begin
      sh = {r, bits[i]};
      if (sh >= d) sh = sh - d;
      r = sh[RemW-1:0];
    end
    return r;
  endfunction

  // Integer neighbour pair and 8-bit weight along one axis
  function automatic axis_t axis_of(logic [PW-1:0] p, logic [SrcDimW-1:0] size);
    axis_t               a;
    logic [PW-FracW-1:0] pi;
    logic [SrcDimW-1:0]  last;
    logic [SrcDimW-1:0]  pn;
    pi   = p[PW-1:FracW];
    last = size - SrcDimW'(1);
    pn   = {1'b0, pi[RemW-1:0]} + SrcDimW'(1);
    a.w  = p[FracW-1:FracW-8];
    if (pi >= {{(PW-FracW-SrcDimW){1'b0}}, size}) begin
      a.i0 = last[RemW-1:0];
      a.i1 = last[RemW-1:0];
    end else begin
      a.i0 = pi[RemW-1:0];
      a.i1 = (pn < size) ? pn[RemW-1:0] : pi[RemW-1:0];
    end
    return a;
  endfunction

  // Composite ARGB over black; divide by 255 through a reciprocal form
  function automatic rgb_t darken(logic [PixW-1:0] c);
    rgb_t        o;
    logic [15:0] v;
    logic [16:0] s;
    if (c[31:24] == 8'hFF) return c[RgbW-1:0];
    o = '0;
    for (int ch = 0; ch < 3; ch++) begin
      v = c[8*ch +: 8] * c[31:24];
      s = {1'b0, v} + {9'b0, v[15:8]} + 17'd1;
      o[8*ch +: 8] = s[15:8];
    end
    return o;
  endfunction

  function automatic logic [7:0] mix8(logic [7:0] a, logic [7:0] b, logic [7:0] w);
    logic [8:0]  wi;
    logic [16:0] pa;
    logic [16:0] pb;
    logic [16:0] s;
    wi = 9'd256 - {1'b0, w};
    pa = a * wi;
    pb = b * w;
    s  = pa + pb;
    return s[15:8];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SrcDimW-1:0] src_w_q, src_h_q;
  logic [ScrDimW-1:0] scr_w_q, scr_h_q;
  logic               tile_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SrcDimW'(256);
      src_h_q <= SrcDimW'(256);
      scr_w_q <= ScrDimW'(1024);
      scr_h_q <= ScrDimW'(768);
      tile_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_SRC_W: src_w_q <= cfg_data_i[SrcDimW-1:0];
        REG_SRC_H: src_h_q <= cfg_data_i[SrcDimW-1:0];
        REG_SCR_W: scr_w_q <= cfg_data_i[ScrDimW-1:0];
        REG_SCR_H: scr_h_q <= cfg_data_i[ScrDimW-1:0];
        REG_TILE:  tile_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [SrcDimW-1:0] wc, hc;
  logic [ScrDimW-1:0] swc, shc;

  assign wc  = clamp_src(src_w_q);
  assign hc  = clamp_src(src_h_q);
  assign swc = clamp_scr(scr_w_q);
  assign shc = clamp_scr(scr_h_q);

  // --------------------------------------------------------------------------
  // Setup: step k, centring offsets, shared serial divider
  // --------------------------------------------------------------------------
  setup_e              su_q;
  logic [DivCntW-1:0]  div_cnt_q;
  logic [ScrDimW-1:0]  div_rem_q, div_den_q;
  logic [KW-1:0]       div_dd_q;
  logic [ScrDimW:0]    div_sh;
  logic                div_ge;
  logic [ScrDimW-1:0]  div_rem_nx;
  logic [KW-1:0]       div_dd_nx;
  logic [KW-1:0]       kx_q, ky_q, k_q, ksw_q, ksh_q;
  logic [OffW-1:0]     offx_q, offy_q, khalf_q;
  logic [KW+ScrDimW-1:0] ksw_full, ksh_full;
  logic [KW-1:0]       remx, remy;
  logic                busy;

  always_comb begin
    div_sh     = {div_rem_q, div_dd_q[KW-1]};
    div_ge     = div_sh >= {1'b0, div_den_q};
    div_rem_nx = div_ge ? ScrDimW'(div_sh - {1'b0, div_den_q}) : div_sh[ScrDimW-1:0];
    div_dd_nx  = {div_dd_q[KW-2:0], div_ge};
  end

  assign ksw_full = k_q * swc;
  assign ksh_full = k_q * shc;
  assign remx     = {wc, FracW'(0)} - ksw_q;
  assign remy     = {hc, FracW'(0)} - ksh_q;
  assign busy     = (su_q != SU_RDY);

  // Advance the setup sequence; restart on any register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      su_q      <= SU_LOAD_X;
      div_cnt_q <= '0;
    end else if (cfg_we_i) begin
      su_q      <= SU_LOAD_X;
      div_cnt_q <= '0;
    end else begin
      case (su_q)
        SU_LOAD_X: begin
          su_q      <= SU_DIV_X;
          div_cnt_q <= '0;
        end
        SU_DIV_X: begin
          div_cnt_q <= div_cnt_q + DivCntW'(1);
          if (div_cnt_q == DivCntW'(KW - 1)) su_q <= SU_LOAD_Y;
        end
        SU_LOAD_Y: begin
          su_q      <= SU_DIV_Y;
          div_cnt_q <= '0;
        end
        SU_DIV_Y: begin
          div_cnt_q <= div_cnt_q + DivCntW'(1);
          if (div_cnt_q == DivCntW'(KW - 1)) su_q <= SU_MIN;
        end
        SU_MIN: su_q <= SU_MUL;
        SU_MUL: su_q <= SU_OFF;
        SU_OFF: su_q <= SU_RDY;
        SU_RDY: ;
        default: su_q <= SU_LOAD_X;
      endcase
    end
  end

  // Setup datapath
  always_ff @(posedge clk_i) begin
    case (su_q)
      SU_LOAD_X: begin
        div_rem_q <= '0;
        div_dd_q  <= {wc, FracW'(0)};
        div_den_q <= swc;
      end
      SU_DIV_X: begin
        div_rem_q <= div_rem_nx;
        div_dd_q  <= div_dd_nx;
        kx_q      <= div_dd_nx;
      end
      SU_LOAD_Y: begin
        div_rem_q <= '0;
        div_dd_q  <= {hc, FracW'(0)};
        div_den_q <= shc;
      end
      SU_DIV_Y: begin
        div_rem_q <= div_rem_nx;
        div_dd_q  <= div_dd_nx;
        ky_q      <= div_dd_nx;
      end
      SU_MIN: k_q <= (kx_q < ky_q) ? kx_q : ky_q;
      SU_MUL: begin
        ksw_q <= ksw_full[KW-1:0];
        ksh_q <= ksh_full[KW-1:0];
      end
      SU_OFF: begin
        offx_q  <= remx[KW-1:1];
        offy_q  <= remy[KW-1:1];
        khalf_q <= k_q[KW-1:1];
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Address pipeline: ready flows back from the memory stage
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, m_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, m_rdy, m_done;
  logic in_acc;

  assign s1_rdy        = !s1_v_q || s2_rdy;
  assign s2_rdy        = !s2_v_q || s3_rdy;
  assign s3_rdy        = !s3_v_q || s4_rdy;
  assign s4_rdy        = !s4_v_q || s5_rdy;
  assign s5_rdy        = !s5_v_q || m_rdy;
  assign m_rdy         = !m_v_q || m_done;
  assign s_axis_tready = s1_rdy && !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      m_v_q  <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= in_acc;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (s4_rdy) s4_v_q <= s3_v_q;
      if (s5_rdy) s5_v_q <= s4_v_q;
      if (m_rdy)  m_v_q  <= s5_v_q;
    end
  end

  // Stage 1: input beat
  op_e               s1_op_q;
  logic [AddrW-1:0]  s1_idx_q;
  logic [PixW-1:0]   s1_val_q;
  logic [DestW-1:0]  s1_x_q, s1_y_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q  <= op_e'(s_axis_tuser);
      s1_idx_q <= s_axis_tdata[15:0];
      s1_val_q <= s_axis_tdata[47:16];
      s1_x_q   <= s_axis_tdata[59:48];
      s1_y_q   <= s_axis_tdata[71:60];
    end
  end

  // Stage 2: step products, first remainder bits
  op_e               s2_op_q;
  logic [AddrW-1:0]  s2_idx_q;
  logic [PixW-1:0]   s2_val_q;
  logic [DestW-1:0]  s2_x_q, s2_y_q;
  logic [ProdW-1:0]  s2_px_q, s2_py_q;
  logic [RemW-1:0]   s2_mx_q, s2_my_q;
  logic [ProdW-1:0]  prod_x, prod_y;

  assign prod_x = k_q * s1_x_q;
  assign prod_y = k_q * s1_y_q;

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_rdy) begin
      s2_op_q  <= s1_op_q;
      s2_idx_q <= s1_idx_q;
      s2_val_q <= s1_val_q;
      s2_x_q   <= s1_x_q;
      s2_y_q   <= s1_y_q;
      s2_px_q  <= prod_x;
      s2_py_q  <= prod_y;
      s2_mx_q  <= mod_step3('0, s1_x_q[11:9], wc);
      s2_my_q  <= mod_step3('0, s1_y_q[11:9], hc);
    end
  end

  // Stage 3: sample positions clamped at zero
  op_e               s3_op_q;
  logic [AddrW-1:0]  s3_idx_q;
  logic [PixW-1:0]   s3_val_q;
  logic [DestW-1:0]  s3_x_q, s3_y_q;
  logic [PW-1:0]     s3_fx_q, s3_fy_q;
  logic [RemW-1:0]   s3_mx_q, s3_my_q;
  logic [PW-1:0]     sum_x, sum_y, f_x, f_y;

  always_comb begin
    sum_x = {1'b0, s2_px_q} + PW'(offx_q) + PW'(khalf_q);
    sum_y = {1'b0, s2_py_q} + PW'(offy_q) + PW'(khalf_q);
    f_x   = (sum_x < PW'(HalfPix)) ? '0 : sum_x - PW'(HalfPix);
    f_y   = (sum_y < PW'(HalfPix)) ? '0 : sum_y - PW'(HalfPix);
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q && s3_rdy) begin
      s3_op_q  <= s2_op_q;
      s3_idx_q <= s2_idx_q;
      s3_val_q <= s2_val_q;
      s3_x_q   <= s2_x_q;
      s3_y_q   <= s2_y_q;
      s3_fx_q  <= f_x;
      s3_fy_q  <= f_y;
      s3_mx_q  <= mod_step3(s2_mx_q, s2_x_q[8:6], wc);
      s3_my_q  <= mod_step3(s2_my_q, s2_y_q[8:6], hc);
    end
  end

  // Stage 4: neighbour indexes and weights
  op_e               s4_op_q;
  logic [AddrW-1:0]  s4_idx_q;
  logic [PixW-1:0]   s4_val_q;
  logic [DestW-1:0]  s4_x_q, s4_y_q;
  axis_t             s4_ax_q, s4_ay_q;
  logic [RemW-1:0]   s4_mx_q, s4_my_q;

  always_ff @(posedge clk_i) begin
    if (s3_v_q && s4_rdy) begin
      s4_op_q  <= s3_op_q;
      s4_idx_q <= s3_idx_q;
      s4_val_q <= s3_val_q;
      s4_x_q   <= s3_x_q;
      s4_y_q   <= s3_y_q;
      s4_ax_q  <= axis_of(s3_fx_q, wc);
      s4_ay_q  <= axis_of(s3_fy_q, hc);
      s4_mx_q  <= mod_step3(s3_mx_q, s3_x_q[5:3], wc);
      s4_my_q  <= mod_step3(s3_my_q, s3_y_q[5:3], hc);
    end
  end

  // Stage 5: pick mode, row bases
  op_e                s5_op_q;
  logic [AddrW-1:0]   s5_idx_q;
  logic [PixW-1:0]    s5_val_q;
  logic [AddrW-1:0]   s5_base0_q, s5_base1_q;
  logic [RemW-1:0]    s5_col0_q, s5_col1_q;
  logic [7:0]         s5_wx_q, s5_wy_q;
  logic [RemW-1:0]    xm, ym, row0, row1, col0, col1;
  logic [7:0]         wx, wy;
  logic [RemW+SrcDimW-1:0] base0, base1;

  always_comb begin
    xm = mod_step3(s4_mx_q, s4_x_q[2:0], wc);
    ym = mod_step3(s4_my_q, s4_y_q[2:0], hc);
    if (tile_q) begin
      row0 = ym;
      row1 = ym;
      col0 = xm;
      col1 = xm;
      wx   = '0;
      wy   = '0;
    end else begin
      row0 = s4_ay_q.i0;
      row1 = s4_ay_q.i1;
      col0 = s4_ax_q.i0;
      col1 = s4_ax_q.i1;
      wx   = s4_ax_q.w;
      wy   = s4_ay_q.w;
    end
    base0 = row0 * wc;
    base1 = row1 * wc;
  end

  always_ff @(posedge clk_i) begin
    if (s4_v_q && s5_rdy) begin
      s5_op_q    <= s4_op_q;
      s5_idx_q   <= s4_idx_q;
      s5_val_q   <= s4_val_q;
      s5_base0_q <= base0[AddrW-1:0];
      s5_base1_q <= base1[AddrW-1:0];
      s5_col0_q  <= col0;
      s5_col1_q  <= col1;
      s5_wx_q    <= wx;
      s5_wy_q    <= wy;
    end
  end

  // --------------------------------------------------------------------------
  // Memory stage: one write, or four reads in turn
  // --------------------------------------------------------------------------
  op_e               m_op_q;
  logic [AddrW-1:0]  m_idx_q;
  logic [PixW-1:0]   m_val_q;
  logic [AddrW-1:0]  m_addr_q [4];
  logic [7:0]        m_wx_q, m_wy_q;
  logic [1:0]        m_cnt_q;
  logic              g_free;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_addr;

  assign mem_we   = m_v_q && (m_op_q == OP_WRITE);
  assign mem_re   = m_v_q && (m_op_q == OP_READ) && ((m_cnt_q != 2'd3) || g_free);
  assign m_done   = m_v_q && ((m_op_q == OP_WRITE) || ((m_cnt_q == 2'd3) && g_free));
  assign mem_addr = mem_we ? m_idx_q : m_addr_q[m_cnt_q];

  always_ff @(posedge clk_i) begin
    if (s5_v_q && m_rdy) begin
      m_op_q      <= s5_op_q;
      m_idx_q     <= s5_idx_q;
      m_val_q     <= s5_val_q;
      m_addr_q[0] <= s5_base0_q + AddrW'(s5_col0_q);
      m_addr_q[1] <= s5_base0_q + AddrW'(s5_col1_q);
      m_addr_q[2] <= s5_base1_q + AddrW'(s5_col0_q);
      m_addr_q[3] <= s5_base1_q + AddrW'(s5_col1_q);
      m_wx_q      <= s5_wx_q;
      m_wy_q      <= s5_wy_q;
    end
  end

  // Step the read counter with each issued read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_cnt_q <= '0;
    end else if (mem_re) begin
      m_cnt_q <= m_cnt_q + 2'd1;
    end
  end

  // Source pixel store
  logic [PixW-1:0] src_mem [MaxSourcePixels];
  logic [PixW-1:0] mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      src_mem[mem_addr] <= m_val_q;
    end else if (mem_re) begin
      mem_rd_q <= src_mem[mem_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Gather the four composited neighbours
  // --------------------------------------------------------------------------
  logic        rd_v_q;
  logic [1:0]  rd_sel_q;
  logic [7:0]  rd_wx_q, rd_wy_q;
  rgb_t        c_pix_q [3];
  rgb_t        rd_pix;
  logic        g_v_q;
  rgb_t        g_pix_q [4];
  logic [7:0]  g_wx_q, g_wy_q;
  logic        g_fill;
  logic        b1_v_q, b1_rdy;
  logic [7:0]  b1_top_q [3];
  logic [7:0]  b1_bot_q [3];
  logic [7:0]  b1_wy_q;
  logic        out_v_q, out_rdy;
  rgb_t        out_rgb_q;
  rgb_t        mix_out;

  assign rd_pix  = darken(mem_rd_q);
  assign g_fill  = rd_v_q && (rd_sel_q == 2'd3);
  assign out_rdy = !out_v_q || m_axis_tready;
  assign b1_rdy  = !b1_v_q || out_rdy;
  assign g_free  = !g_v_q || b1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      rd_sel_q <= '0;
      g_v_q    <= 1'b0;
      b1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      rd_v_q   <= mem_re;
      rd_sel_q <= m_cnt_q;
      if (g_fill)      g_v_q <= 1'b1;
      else if (b1_rdy) g_v_q <= 1'b0;
      if (b1_rdy)  b1_v_q  <= g_v_q;
      if (out_rdy) out_v_q <= b1_v_q;
    end
  end

  // Hold weights of the item being read, collect its pixels
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_wx_q <= m_wx_q;
      rd_wy_q <= m_wy_q;
    end
    if (rd_v_q && !g_fill) c_pix_q[rd_sel_q] <= rd_pix;
    if (g_fill) begin
      g_pix_q[0] <= c_pix_q[0];
      g_pix_q[1] <= c_pix_q[1];
      g_pix_q[2] <= c_pix_q[2];
      g_pix_q[3] <= rd_pix;
      g_wx_q     <= rd_wx_q;
      g_wy_q     <= rd_wy_q;
    end
  end

  // --------------------------------------------------------------------------
  // Blend: horizontal, then vertical, then output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (g_v_q && b1_rdy) begin
      for (int ch = 0; ch < 3; ch++) begin
        b1_top_q[ch] <= mix8(g_pix_q[0][8*ch +: 8], g_pix_q[1][8*ch +: 8], g_wx_q);
        b1_bot_q[ch] <= mix8(g_pix_q[2][8*ch +: 8], g_pix_q[3][8*ch +: 8], g_wx_q);
      end
      b1_wy_q <= g_wy_q;
    end
  end

  always_comb begin
    mix_out = '0;
    for (int ch = 0; ch < 3; ch++) begin
      mix_out[8*ch +: 8] = mix8(b1_top_q[ch], b1_bot_q[ch], b1_wy_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_v_q && out_rdy) out_rgb_q <= mix_out;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_rgb_q;

endmodule

`default_nettype wire

// ----- hdl/bcts_checker.sv -----
// ============================================================================
// bcts_checker
// Port-level checks of the bilinear cover / tile scaler.
// ============================================================================
`default_nettype none

module bcts_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bcts_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // pixel_index[15:0], pixel_value[47:16], dest_x[59:48], dest_y[71:60]
  input  logic [bcts_pkg::InDataW-1:0]  s_axis_tdata,
  // operation[0]
  input  logic                          s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // screen_rgb[23:0]
  input  logic [bcts_pkg::RgbW-1:0]     m_axis_tdata
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // Block input while the scale step is recomputed
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input ready right after a register write");

  a_reset_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("input ready right after reset");

endmodule

bind bilinear_cover_or_tile_scaler bcts_checker u_bcts_checker (.*);

`default_nettype wire
